// ===== hw/rtl/mbcrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbcrc_pkg: shared types and helpers for the Modbus RTU CRC framer
// Request opcodes, frame status codes, field widths and the byte-wide
// CRC-16/MODBUS update (reflected polynomial 0xA001).
// ----------------------------------------------------------------------------
package mbcrc_pkg;

  localparam int unsigned CountBitsDef = 32;
  localparam int unsigned TotalW       = 32;
  localparam int unsigned LenW         = 9;
  localparam int unsigned MinFrame     = 4;

  localparam logic [LenW-1:0] FrameCap = 9'd256;
  localparam logic [15:0]     CrcInit  = 16'hFFFF;
  localparam logic [15:0]     CrcPoly  = 16'hA001;

  typedef enum logic [1:0] {
    OP_RX_BYTE = 2'd0,
    OP_RX_END  = 2'd1,
    OP_TX_BYTE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_CRC = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  localparam logic KindTx     = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Fold one byte into the running CRC, low bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/modbus_rtu_crc_framer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_crc_framer_top: Modbus RTU framer with CRC-16/MODBUS
// Appends the CRC to transmit frames and checks it on received frames.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_*): one request per beat. in_tuser carries the opcode
//   (receive byte, receive frame end, transmit byte) and the scan flag,
//   in_tdata the byte, in_tlast marks the final command byte of a transmit
//   frame.
//   Result channel (out_*): transmit bytes (command bytes, then CRC low and
//   CRC high with out_tlast set) and one status beat per frame end, each
//   carrying the three saturating frame counters.
//   Configuration: cfg_wr_en/cfg_wr_data write max_frame_len; write it only
//   while the block is idle. Values above 256 act as 256.
// Timing
//   A request lands in the input register, and its result is then registered
//   in the output register, which drives out_tvalid.
//   One request per cycle is taken while the result channel does not stall; a
//   transmit byte marked last produces three results and holds off the next
//   request while the CRC pair is emitted. Received bytes produce no result.
// Reset and stall
//   rst_n (synchronous, active low) clears both running CRCs, the receive delay line,
//   the counters and both valid flags, and sets max_frame_len to 256.
//   While out_tready is low the result is held; the input register fills and
//   then in_tready drops.
// ----------------------------------------------------------------------------
module modbus_rtu_crc_framer_top
  import mbcrc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // configuration
  input  wire logic          cfg_wr_en,
  input  wire logic [8:0]    cfg_wr_data,  // max_frame_len
  // request channel
  input  wire logic          in_tvalid,
  output      logic          in_tready,
  input  wire logic [7:0]    in_tdata,     // [7:0] data
  input  wire logic          in_tlast,     // last
  input  wire logic [2:0]    in_tuser,     // [1:0] op, [2] scan
  // result channel
  output      logic          out_tvalid,
  input  wire logic          out_tready,
  output      logic [119:0]  out_tdata,    // [7:0] out_byte, [9:8] status,
                                           // [18:10] frame_len,
                                           // [50:19] success_total,
                                           // [82:51] crcfail_total,
                                           // [114:83] timeout_total, zero pad
  output      logic          out_tlast,    // out_last
  output      logic [0:0]    out_tuser     // [0] kind
);

  localparam int unsigned ExtW = (COUNT_BITS > TotalW) ? COUNT_BITS : TotalW;

  // configuration
  logic [LenW-1:0] max_len_r;

  // input register
  logic            in_vld_r;
  op_t             in_op_r;
  logic [7:0]      in_data_r;
  logic            in_last_r;
  logic            in_scan_r;

  // framing state
  logic [15:0]     rx_crc_r,   rx_crc_nxt;
  logic [7:0]      rx_hold0_r, rx_hold0_nxt;
  logic [7:0]      rx_hold1_r, rx_hold1_nxt;
  logic [LenW-1:0] rx_cnt_r,   rx_cnt_nxt;
  logic [15:0]     tx_crc_r,   tx_crc_nxt;
  logic [COUNT_BITS-1:0] good_r, good_nxt;
  logic [COUNT_BITS-1:0] bad_r,  bad_nxt;
  logic [COUNT_BITS-1:0] sil_r,  sil_nxt;

  // CRC pair still to emit after a last transmit byte
  logic [1:0]      tail_cnt_r, tail_cnt_nxt;
  logic [15:0]     tail_crc_r, tail_crc_nxt;

  // output register
  logic            out_vld_r, out_vld_nxt;
  logic            out_kind_r, out_kind_nxt;
  logic [7:0]      out_byte_r, out_byte_nxt;
  logic            out_last_r, out_last_nxt;
  logic [1:0]      out_stat_r, out_stat_nxt;
  logic [LenW-1:0] out_len_r,  out_len_nxt;
  logic [TotalW-1:0] out_good_r, out_bad_r, out_sil_r;
  logic            out_ld;

  logic            out_free;
  logic            needs_out;
  logic            item_adv;
  logic [LenW-1:0] limit;
  logic [15:0]     rx_crc_step;
  logic [15:0]     tx_crc_step;
  logic            crc_ok;
  logic [ExtW-1:0] good_ext, bad_ext, sil_ext;

  assign out_free  = !out_vld_r || out_tready;
  assign needs_out = (in_op_r == OP_RX_END) || (in_op_r == OP_TX_BYTE);
  // Advance a held request only after the CRC tail, and only if its result has a free slot.
  assign item_adv  = in_vld_r && (tail_cnt_r == 2'd0) && (!needs_out || out_free);
  assign in_tready = !in_vld_r || item_adv;

  assign limit       = (max_len_r > FrameCap) ? FrameCap : max_len_r;
  assign rx_crc_step = crc_byte(rx_crc_r, rx_hold0_r);
  assign tx_crc_step = crc_byte(tx_crc_r, in_data_r);
  assign crc_ok      = (rx_hold0_r == rx_crc_r[7:0]) && (rx_hold1_r == rx_crc_r[15:8]);

  always_comb begin
    rx_crc_nxt   = rx_crc_r;
    rx_hold0_nxt = rx_hold0_r;
    rx_hold1_nxt = rx_hold1_r;
    rx_cnt_nxt   = rx_cnt_r;
    tx_crc_nxt   = tx_crc_r;
    good_nxt     = good_r;
    bad_nxt      = bad_r;
    sil_nxt      = sil_r;
    tail_cnt_nxt = tail_cnt_r;
    tail_crc_nxt = tail_crc_r;
    out_ld       = 1'b0;
    out_kind_nxt = KindTx;
    out_byte_nxt = 8'h00;
    out_last_nxt = 1'b0;
    out_stat_nxt = ST_OK;
    out_len_nxt  = '0;

    if (tail_cnt_r != 2'd0) begin
      if (out_free) begin
        // Emit CRC low byte, then CRC high byte closing the run.
        out_ld       = 1'b1;
        tail_cnt_nxt = tail_cnt_r - 2'd1;
        if (tail_cnt_r == 2'd2) begin
          out_byte_nxt = tail_crc_r[7:0];
        end else begin
          out_byte_nxt = tail_crc_r[15:8];
          out_last_nxt = 1'b1;
        end
      end
    end else if (item_adv) begin
      case (in_op_r)
        OP_RX_BYTE: begin
          // Drop bytes past the length limit.
          if (rx_cnt_r < limit) begin
            if (rx_cnt_r >= LenW'(2)) begin
              rx_crc_nxt = rx_crc_step;
            end
            rx_hold0_nxt = rx_hold1_r;
            rx_hold1_nxt = in_data_r;
            rx_cnt_nxt   = rx_cnt_r + 1'b1;
          end
        end
        OP_RX_END: begin
          out_ld       = 1'b1;
          out_kind_nxt = KindStatus;
          out_len_nxt  = rx_cnt_r;
          if (rx_cnt_r >= LenW'(MinFrame)) begin
            out_stat_nxt = crc_ok ? ST_OK : ST_BAD_CRC;
            if (!in_scan_r) begin
              if (crc_ok) begin
                good_nxt = (good_r == '1) ? good_r : good_r + 1'b1;
              end else begin
                bad_nxt  = (bad_r == '1) ? bad_r : bad_r + 1'b1;
              end
            end
          end else begin
            out_stat_nxt = ST_TIMEOUT;
            if (!in_scan_r) begin
              sil_nxt = (sil_r == '1) ? sil_r : sil_r + 1'b1;
            end
          end
          rx_crc_nxt   = CrcInit;
          rx_hold0_nxt = 8'h00;
          rx_hold1_nxt = 8'h00;
          rx_cnt_nxt   = '0;
        end
        OP_TX_BYTE: begin
          out_ld       = 1'b1;
          out_byte_nxt = in_data_r;
          tx_crc_nxt   = tx_crc_step;
          if (in_last_r) begin
            tail_cnt_nxt = 2'd2;
            tail_crc_nxt = tx_crc_step;
            tx_crc_nxt   = CrcInit;
          end
        end
        default: begin
          // unused opcode: consume silently
        end
      endcase
    end
  end

  assign out_vld_nxt = out_ld ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);

  assign good_ext = ExtW'(good_nxt);
  assign bad_ext  = ExtW'(bad_nxt);
  assign sil_ext  = ExtW'(sil_nxt);

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= FrameCap;
      in_vld_r   <= 1'b0;
      rx_crc_r   <= CrcInit;
      rx_hold0_r <= 8'h00;
      rx_hold1_r <= 8'h00;
      rx_cnt_r   <= '0;
      tx_crc_r   <= CrcInit;
      good_r     <= '0;
      bad_r      <= '0;
      sil_r      <= '0;
      tail_cnt_r <= 2'd0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      rx_crc_r   <= rx_crc_nxt;
      rx_hold0_r <= rx_hold0_nxt;
      rx_hold1_r <= rx_hold1_nxt;
      rx_cnt_r   <= rx_cnt_nxt;
      tx_crc_r   <= tx_crc_nxt;
      good_r     <= good_nxt;
      bad_r      <= bad_nxt;
      sil_r      <= sil_nxt;
      tail_cnt_r <= tail_cnt_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r   <= op_t'(in_tuser[1:0]);
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
      in_scan_r <= in_tuser[2];
    end
    tail_crc_r <= tail_crc_nxt;
    if (out_ld) begin
      out_kind_r <= out_kind_nxt;
      out_byte_r <= out_byte_nxt;
      out_last_r <= out_last_nxt;
      out_stat_r <= out_stat_nxt;
      out_len_r  <= out_len_nxt;
      out_good_r <= good_ext[TotalW-1:0];
      out_bad_r  <= bad_ext[TotalW-1:0];
      out_sil_r  <= sil_ext[TotalW-1:0];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {5'b0, out_sil_r, out_bad_r, out_good_r, out_len_r, out_stat_r,
                       out_byte_r};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_tail_blocks_item: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_cnt_r != 2'd0) |-> !item_adv)
    else $error("request advanced while CRC tail pending");

  a_last_tx_arms_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (item_adv && (in_op_r == OP_TX_BYTE) && in_last_r) |=> (tail_cnt_r == 2'd2))
    else $error("last transmit byte did not arm CRC tail");

  a_tlast_only_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_last_r) |-> (out_kind_r == KindTx))
    else $error("run end flagged on a status result");

  a_rx_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    rx_cnt_r <= FrameCap)
    else $error("receive count beyond frame cap");

  a_status_clears_rx: assert property (@(posedge clk) disable iff (!rst_n)
    (item_adv && (in_op_r == OP_RX_END)) |=> (rx_cnt_r == '0 && rx_crc_r == CrcInit))
    else $error("frame end did not clear receive state");

endmodule
`default_nettype wire

// ===== sim/tb_modbus_rtu_crc_framer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_crc_framer_top: self-checking bench for the Modbus RTU framer
// Drives receive bytes, frame ends and transmit bytes over the request stream.
// A scoreboard class predicts each result line (transmit bytes with the
// appended CRC pair, frame status with the three counters) and checks every
// accepted result in order. Both stream sides idle at random, the receiver
// holds off once for a long stretch, and max_frame_len is swept across
// its extremes between phases.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_crc_framer_top;
  import mbcrc_pkg::*;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned PhaseItems    = 8;
  localparam int unsigned NumPhases     = 8;
  // The fourth opcode has no function; the block must drop it silently.
  localparam logic [1:0]  OpUnused      = 2'd3;

  // One result line as it leaves the block.
  typedef struct {
    logic              kind;
    logic [7:0]        octet;
    logic              last;
    status_t           status;
    logic [LenW-1:0]   len;
    logic [TotalW-1:0] good;
    logic [TotalW-1:0] bad;
    logic [TotalW-1:0] silent;
  } line_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the framer state and holds the result lines still due.
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    logic [LenW-1:0]   frame_limit;
    logic [15:0]       rx_crc;
    logic [15:0]       tx_crc;
    logic [7:0]        rx_hold [2];
    logic [LenW-1:0]   rx_count;
    logic [TotalW-1:0] good_total;
    logic [TotalW-1:0] bad_total;
    logic [TotalW-1:0] silent_total;
    line_t             due_lines [$];
    int                mismatches;

    function new();
      frame_limit  = FrameCap;
      tx_crc       = CrcInit;
      good_total   = '0;
      bad_total    = '0;
      silent_total = '0;
      mismatches   = 0;
      clear_rx();
    endfunction

    // Reflected CRC-16 update, one bit per step, low bit first.
    static function logic [15:0] fold_crc(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      repeat (8) begin
        c = {1'b0, c[15:1]} ^ (c[0] ? 16'hA001 : 16'h0000);
      end
      return c;
    endfunction

    function void clear_rx();
      rx_crc     = CrcInit;
      rx_hold[0] = 8'h00;
      rx_hold[1] = 8'h00;
      rx_count   = '0;
    endfunction

    function logic [TotalW-1:0] bump(logic [TotalW-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function void push_line(logic kind, logic [7:0] octet, logic last, status_t st,
                            logic [LenW-1:0] len);
      line_t l;
      l.kind   = kind;
      l.octet  = octet;
      l.last   = last;
      l.status = st;
      l.len    = len;
      l.good   = good_total;
      l.bad    = bad_total;
      l.silent = silent_total;
      due_lines.push_back(l);
    endfunction

    // Advance the state by one accepted request and queue its result lines.
    function void note_request(logic [1:0] op, logic [7:0] data, logic last, logic scan);
      logic [LenW-1:0] cap;
      logic [LenW-1:0] len;
      logic            ok;
      status_t         st;
      case (op)
        OP_RX_BYTE: begin
          cap = (frame_limit > FrameCap) ? FrameCap : frame_limit;
          if (rx_count < cap) begin
            if (rx_count >= 2) rx_crc = fold_crc(rx_crc, rx_hold[0]);
            rx_hold[0] = rx_hold[1];
            rx_hold[1] = data;
            rx_count   = rx_count + 1'b1;
          end
        end
        OP_RX_END: begin
          len = rx_count;
          if (len >= MinFrame) begin
            ok = (rx_hold[0] == rx_crc[7:0]) && (rx_hold[1] == rx_crc[15:8]);
            st = ok ? ST_OK : ST_BAD_CRC;
            if (!scan) begin
              if (ok) good_total = bump(good_total);
              else bad_total = bump(bad_total);
            end
          end else begin
            st = ST_TIMEOUT;
            if (!scan) silent_total = bump(silent_total);
          end
          clear_rx();
          push_line(KindStatus, 8'h00, 1'b0, st, len);
        end
        OP_TX_BYTE: begin
          tx_crc = fold_crc(tx_crc, data);
          push_line(KindTx, data, 1'b0, ST_OK, '0);
          if (last) begin
            push_line(KindTx, tx_crc[7:0], 1'b0, ST_OK, '0);
            push_line(KindTx, tx_crc[15:8], 1'b1, ST_OK, '0);
            tx_crc = CrcInit;
          end
        end
        default: begin
        end
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got 0x%0h want 0x%0h", what, got, want);
      mismatches++;
    endtask

    task check_line(line_t got);
      line_t want;
      if (due_lines.size() == 0) begin
        report("result with nothing due", {31'd0, got.kind}, 32'd0);
        return;
      end
      want = due_lines.pop_front();
      if (got.kind !== want.kind) report("kind", {31'd0, got.kind}, {31'd0, want.kind});
      if (got.octet !== want.octet) report("out_byte", {24'd0, got.octet}, {24'd0, want.octet});
      if (got.last !== want.last) report("out_last", {31'd0, got.last}, {31'd0, want.last});
      if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
      if (got.len !== want.len) report("frame_len", 32'(got.len), 32'(want.len));
      if (got.good !== want.good) report("success_total", got.good, want.good);
      if (got.bad !== want.bad) report("crcfail_total", got.bad, want.bad);
      if (got.silent !== want.silent) report("timeout_total", got.silent, want.silent);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value.
  // --------------------------------------------------------------------------
  logic         clk         = 1'b0;
  logic         rst_n       = 1'b0;
  logic         cfg_wr_en   = 1'b0;
  logic [8:0]   cfg_wr_data = '0;
  logic         in_tvalid   = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata    = '0;
  logic         in_tlast    = 1'b0;
  logic [2:0]   in_tuser    = '0;
  logic         out_tvalid;
  logic         out_tready  = 1'b0;
  logic [119:0] out_tdata;
  logic         out_tlast;
  logic [0:0]   out_tuser;

  frame_scoreboard sb;
  int unsigned     sent_items = 0;
  // calm: no idling on either side; hold_req: ask the sink for a long hold-off
  bit              calm       = 1'b0;
  bit              hold_req   = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  modbus_rtu_crc_framer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Mostly no gap, often a short one, rarely a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly short payloads, a few longer ones.
  function automatic int payload_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(2, 8);
    if (r < 92) return $urandom_range(0, 20);
    return $urandom_range(20, 40);
  endfunction

  // Offer one request, wait for its handshake, then idle for a random gap.
  // Keep tvalid high when no gap follows so it is never dropped and re-raised
  // within one time step.
  task automatic send(logic [1:0] op, logic [7:0] data, logic last, logic scan);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tlast  <= last;
    in_tuser  <= {scan, op};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, data, last, scan);
    if (op != OpUnused) sent_items++;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Build a receive frame: n random payload bytes, optionally the matching
  // CRC pair, optionally one flipped bit, then the frame end.
  task automatic send_rx_frame(int n, bit with_crc, bit corrupt, bit scan);
    logic [7:0]  frame_bytes [$];
    logic [7:0]  b;
    logic [15:0] crc;
    int          k;
    crc = CrcInit;
    for (k = 0; k < n; k++) begin
      b = 8'($urandom);
      frame_bytes.push_back(b);
      crc = frame_scoreboard::fold_crc(crc, b);
    end
    if (with_crc) begin
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
    end
    if (corrupt && frame_bytes.size() > 0) begin
      k = $urandom_range(0, frame_bytes.size() - 1);
      frame_bytes[k] = frame_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    // last and scan mean nothing on receive bytes; toggle them anyway
    foreach (frame_bytes[i]) send(OP_RX_BYTE, frame_bytes[i], 1'($urandom), 1'($urandom));
    send(OP_RX_END, 8'($urandom), 1'($urandom), scan);
  endtask

  task automatic send_tx_frame(int n);
    for (int k = 0; k < n; k++) send(OP_TX_BYTE, 8'($urandom), k == n - 1, 1'($urandom));
  endtask

  // Drop tvalid, wait until every due line has come, then cover requests
  // still in flight that produce no result (received bytes).
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.due_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [8:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.frame_limit = v;
    cfg_wr_en <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result sink: check each accepted line, then pick the next tready value.
  // The long hold-off is counted here so the sender keeps pushing meanwhile.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int    gap_left;
    int    hold_left;
    line_t got;
    gap_left  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.kind   = out_tuser[0];
        got.octet  = out_tdata[7:0];
        got.last   = out_tlast;
        got.status = status_t'(out_tdata[9:8]);
        got.len    = out_tdata[18:10];
        got.good   = out_tdata[50:19];
        got.bad    = out_tdata[82:51];
        got.silent = out_tdata[114:83];
        sb.check_line(got);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm) gap_left = idle_len();
      end
    end
  end

  // Hard stop if the run hangs.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles <= CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed corners first, then random phases over frame limits.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [8:0]  limits [NumPhases];
    logic [8:0]  v;
    int unsigned phase_end;
    int          r;
    sb = new();
    limits = '{9'd4, 9'd5, 9'd3, 9'd0, 9'd511, 9'd300, 9'd16, 9'd256};

    // Hold reset, then release it and write the reset value explicitly.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_limit(FrameCap);

    // Transmit: one-byte frame, then a two-byte frame with extreme bytes.
    send(OP_TX_BYTE, 8'h00, 1'b1, 1'b0);
    send(OP_TX_BYTE, 8'hFF, 1'b0, 1'b1);
    send(OP_TX_BYTE, 8'h80, 1'b1, 1'b0);
    // Frame end with nothing received: counted timeout, then a scan timeout.
    send(OP_RX_END, 8'hFF, 1'b1, 1'b0);
    send(OP_RX_END, 8'h00, 1'b0, 1'b1);
    // Shortest valid frame, the same as a scan, a bad CRC, and a short frame.
    send_rx_frame(2, 1'b1, 1'b0, 1'b0);
    send_rx_frame(2, 1'b1, 1'b0, 1'b1);
    send_rx_frame(2, 1'b1, 1'b1, 1'b0);
    send_rx_frame(3, 1'b0, 1'b0, 1'b0);
    // Unused opcode with every other field high: no result, no state change.
    send(OpUnused, 8'hFF, 1'b1, 1'b1);

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      v = (p == 6) ? 9'($urandom_range(6, 40)) : limits[p];
      write_limit(v);
      // A stretch with no idling on either side.
      calm = (p == 1);
      // Oversized frame: the limit above 256 must act as 256.
      if (v == 9'd511) send_rx_frame(258, 1'b1, 1'b0, 1'b0);
      // Pressure: hold the sink off while the sender streams back to back,
      // so the block fills and stalls its input.
      if (p == NumPhases - 1) begin
        calm     = 1'b1;
        hold_req = 1'b1;
        send_tx_frame(8);
        send_tx_frame(1);
        send_tx_frame(11);
        calm = 1'b0;
      end
      phase_end = sent_items + PhaseItems;
      while (sent_items < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 40) send_rx_frame(payload_len(), 1'b1, 1'b0, $urandom_range(0, 3) == 0);
        else if (r < 52) send_rx_frame(payload_len(), 1'b1, 1'b1, $urandom_range(0, 3) == 0);
        else if (r < 60) send_rx_frame($urandom_range(0, 3), 1'b0, 1'b0, 1'($urandom));
        else if (r < 85) send_tx_frame($urandom_range(1, 12));
        else if (r < 96) send(2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
        else send(OpUnused, 8'($urandom), 1'($urandom), 1'($urandom));
      end
    end

    // Drain, then flag anything that never showed up.
    settle();
    repeat (4) @(posedge clk);
    if (sb.due_lines.size() != 0) sb.report("lines never delivered", sb.due_lines.size(), 0);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mbcrc_pkg.sv
hw/rtl/modbus_rtu_crc_framer_top.sv
sim/tb_modbus_rtu_crc_framer_top.sv
